/* hdl/sfpp_pkg.sv */
// Shared types and constants for the starfield particle projector.
package sfpp_pkg;

    // Command codes
    localparam logic CMD_INIT    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Field widths
    localparam int AGE_W    = 8;
    localparam int SEED_W   = 10;
    localparam int IDX_W    = 10;
    localparam int LIMIT_W  = 11;
    localparam int OFS_W    = 12;
    localparam int MASK_W   = 8;
    localparam int PLANE_W  = 2;
    localparam int LCG_W    = 32;
    localparam int LCG_MW   = 18;
    localparam int LCG_PW   = LCG_W + LCG_MW;
    localparam int LCG_KEEP = 48;
    localparam int RECIP_W  = 15;
    localparam int PROD_W   = SEED_W + RECIP_W + 1;
    localparam int FRAC_W   = 14;
    localparam int POS_W    = PROD_W - FRAC_W;
    localparam int AGE_N    = 1 << AGE_W;

    // LCG
    localparam logic [LCG_MW-1:0] LCG_MUL   = 18'h343FD;
    localparam logic [LCG_W-1:0]  LCG_ADD   = 32'h0026_9EC3;
    localparam logic [SEED_W-1:0] SEED_FLIP = 10'h200;

    // Age handling
    localparam logic [AGE_W-1:0] AGE_STEP   = 8'd2;
    localparam logic [AGE_W-1:0] AGE_WRAP   = 8'hF0;
    localparam logic [AGE_W-1:0] PLANE0_AGE = 8'd180;
    localparam logic [AGE_W-1:0] PLANE1_AGE = 8'd110;

    // Plane codes
    localparam logic [PLANE_W-1:0] PLANE_NONE = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_0    = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_1    = 2'd2;
    localparam logic [PLANE_W-1:0] PLANE_BOTH = 2'd3;

    // Projection
    localparam int Y_NUMER    = 108 << 16;
    localparam int X_NUMER    = 144 << 16;
    localparam int DEPTH_BASE = 150;
    localparam int DEPTH_STEP = 4;

    localparam logic signed [POS_W-1:0] Y_CENTRE = 12'sd100;
    localparam logic signed [POS_W-1:0] X_CENTRE = 12'sd160;
    localparam logic signed [POS_W-1:0] Y_LAST   = 12'sd99;
    localparam logic signed [POS_W-1:0] X_LAST   = 12'sd319;
    localparam logic [OFS_W-1:0]        ROW_BYTES = 12'd40;
    localparam logic [MASK_W-1:0]       PIXEL_MSB = 8'h80;

    typedef struct packed {
        logic                command;
        logic [IDX_W-1:0]    star_index;
        logic [IDX_W-1:0]    countdown;
        logic [LIMIT_W-1:0]  plot_limit;
    } job_t;

    typedef struct packed {
        logic                plot_valid;
        logic [OFS_W-1:0]    byte_offset;
        logic [MASK_W-1:0]   pixel_mask;
        logic [PLANE_W-1:0]  plane_select;
        logic                reseeded;
    } plot_t;

    typedef struct packed {
        logic [AGE_W-1:0]  age;
        logic [SEED_W-1:0] x_seed;
        logic [SEED_W-1:0] y_seed;
    } star_rec_t;

    localparam int REC_W = $bits(star_rec_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAW_MUL_X,
        ST_DRAW_ADD_X,
        ST_DRAW_MUL_Y,
        ST_DRAW_ADD_Y,
        ST_FINISH
    } sfpp_state_t;

endpackage

/* hdl/sfpp_if.sv */
// Valid/ready channel interfaces for star jobs and plot words.
interface sfpp_job_if import sfpp_pkg::*;;
    logic valid;
    logic ready;
    job_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfpp_plot_if import sfpp_pkg::*;;
    logic  valid;
    logic  ready;
    plot_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sfpp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module sfpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/starfield_particle_projector_core.sv */
// Starfield particle projector: star table, LCG reseeding and depth projection.
// An advance reads the record in ST_READ, registers the projection products, then loads
// the output word in ST_FINISH; an init runs the draw states, and a reseeding advance
// goes from ST_READ to them (two registered LCG multiplies, each followed by an add).
// A new word is taken only in ST_IDLE, or in ST_FINISH once the output register is free.
// Reset clears the sequencer, the output register and the LCG seed; the star memory
// is not cleared and holds nothing meaningful until each record is initialised.
module starfield_particle_projector_core import sfpp_pkg::*; #(
    parameter int STAR_COUNT = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    sfpp_job_if.sink     job,
    sfpp_plot_if.source  plot
);

    localparam int ADDR_W = $clog2(STAR_COUNT);

    // Reciprocal depth tables, one entry per age, worked out at elaboration.
    logic [RECIP_W-1:0] recip_y_tab [AGE_N];
    logic [RECIP_W-1:0] recip_x_tab [AGE_N];

    for (genvar a = 0; a < AGE_N; a++)
    begin : g_recip
        localparam int RecipY = (Y_NUMER / (DEPTH_BASE + DEPTH_STEP * a)) >> 1;
        localparam int RecipX = (X_NUMER / (DEPTH_BASE + DEPTH_STEP * a)) >> 1;
        assign recip_y_tab[a] = RECIP_W'(RecipY);
        assign recip_x_tab[a] = RECIP_W'(RecipX);
    end

    // Control registers
    sfpp_state_t state_reg, state_next;
    logic [LCG_W-1:0] lcg_seed_reg, lcg_seed_next;
    logic out_valid_reg, out_valid_next;

    // Payload registers
    logic              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              in_range_reg, in_range_next;
    logic              draw_ok_reg, draw_ok_next;
    logic              plot_en_reg, plot_en_next;
    logic              reseed_reg, reseed_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic [SEED_W-1:0] x_new_reg, x_new_next;
    logic [LCG_KEEP-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] proj_y_reg, proj_y_next;
    logic signed [PROD_W-1:0] proj_x_reg, proj_x_next;
    plot_t out_word_reg, out_word_next;

    // Star memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    star_rec_t         ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [REC_W-1:0]  ram_rdata;

    sfpp_ram #(
        .WIDTH (REC_W),
        .DEPTH (STAR_COUNT)
    ) u_star_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake
    logic out_free;
    logic accept;
    logic job_in_range;

    assign out_free     = !out_valid_reg || plot.ready;
    assign job.ready    = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && out_free);
    assign accept       = job.valid && job.ready;
    assign job_in_range = int'(job.data.star_index) < STAR_COUNT;

    assign plot.valid = out_valid_reg;
    assign plot.data  = out_word_reg;

    // LCG step: full product of the multiplier constant and the current seed.
    logic [LCG_PW-1:0] lcg_prod_full;
    assign lcg_prod_full = LCG_MUL * lcg_seed_reg;

    // Fresh 10-bit seed from the product held in prod_reg: (rand & 1023) - 512.
    logic [SEED_W-1:0] drawn_seed;
    assign drawn_seed = prod_reg[LCG_W +: SEED_W] ^ SEED_FLIP;

    // Record read back and its aged value
    star_rec_t        rd_rec;
    logic [AGE_W-1:0] aged;
    assign rd_rec = ram_rdata;
    assign aged   = rd_rec.age - AGE_STEP;

    // Init age: (index & 255) - 1, floored at zero
    logic [AGE_W-1:0] init_age;
    assign init_age = (job.data.star_index[AGE_W-1:0] == '0) ? '0
                    : job.data.star_index[AGE_W-1:0] - AGE_W'(1);

    // Projection result from the registered products
    logic signed [POS_W-1:0] y_pos, x_pos;
    logic                    on_screen;
    logic                    plot_hit;
    logic [OFS_W-1:0]        row_base;
    logic [PLANE_W-1:0]      plane;

    assign y_pos     = $signed(proj_y_reg[PROD_W-1:FRAC_W]) + Y_CENTRE;
    assign x_pos     = $signed(proj_x_reg[PROD_W-1:FRAC_W]) + X_CENTRE;
    assign on_screen = !y_pos[POS_W-1] && (y_pos <= Y_LAST)
                    && !x_pos[POS_W-1] && (x_pos <= X_LAST);
    assign plot_hit  = plot_en_reg && on_screen;
    assign row_base  = {5'b0, y_pos[6:0]} * ROW_BYTES;

    always_comb
    begin
        if (age_reg >= PLANE0_AGE)
        begin
            plane = PLANE_0;
        end
        else if (age_reg >= PLANE1_AGE)
        begin
            plane = PLANE_1;
        end
        else
        begin
            plane = PLANE_BOTH;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        lcg_seed_next  = lcg_seed_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        in_range_next  = in_range_reg;
        draw_ok_next   = draw_ok_reg;
        plot_en_next   = plot_en_reg;
        reseed_next    = reseed_reg;
        age_next       = age_reg;
        x_new_next     = x_new_reg;
        prod_next      = prod_reg;
        proj_y_next    = proj_y_reg;
        proj_x_next    = proj_x_reg;
        out_word_next  = out_word_reg;

        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(idx_reg);
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(job.data.star_index);

        // Drop the output word once taken
        if (out_valid_reg && plot.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
            end

            ST_READ:
            begin
                if (in_range_reg && (cmd_reg == CMD_ADVANCE))
                begin
                    age_next = aged;
                    if (aged > AGE_WRAP)
                    begin
                        // Age wrapped: draw new seeds, no plot
                        reseed_next = 1'b1;
                        state_next  = ST_DRAW_MUL_X;
                    end
                    else
                    begin
                        ram_we       = 1'b1;
                        ram_wdata    = '{age: aged, x_seed: rd_rec.x_seed,
                                         y_seed: rd_rec.y_seed};
                        proj_y_next  = $signed(rd_rec.y_seed)
                                     * $signed({1'b0, recip_y_tab[aged]});
                        proj_x_next  = $signed(rd_rec.x_seed)
                                     * $signed({1'b0, recip_x_tab[aged]});
                        plot_en_next = draw_ok_reg;
                        state_next   = ST_FINISH;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_DRAW_MUL_X:
            begin
                prod_next  = lcg_prod_full[LCG_KEEP-1:0];
                state_next = ST_DRAW_ADD_X;
            end

            ST_DRAW_ADD_X:
            begin
                lcg_seed_next = prod_reg[LCG_W-1:0] + LCG_ADD;
                x_new_next    = drawn_seed;
                state_next    = ST_DRAW_MUL_Y;
            end

            ST_DRAW_MUL_Y:
            begin
                prod_next  = lcg_prod_full[LCG_KEEP-1:0];
                state_next = ST_DRAW_ADD_Y;
            end

            ST_DRAW_ADD_Y:
            begin
                lcg_seed_next = prod_reg[LCG_W-1:0] + LCG_ADD;
                ram_we        = 1'b1;
                ram_wdata     = '{age: age_reg, x_seed: x_new_reg, y_seed: drawn_seed};
                state_next    = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_word_next.plot_valid   = plot_hit;
                    out_word_next.byte_offset  = plot_hit
                                               ? row_base + {6'b0, x_pos[8:3]} : '0;
                    out_word_next.pixel_mask   = plot_hit ? PIXEL_MSB >> x_pos[2:0] : '0;
                    out_word_next.plane_select = plot_hit ? plane : PLANE_NONE;
                    out_word_next.reseeded     = reseed_reg;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Take a new job word: read the record for an advance, start drawing for an init
        if (accept)
        begin
            cmd_next      = job.data.command;
            idx_next      = job.data.star_index;
            in_range_next = job_in_range;
            draw_ok_next  = {1'b0, job.data.countdown} >= job.data.plot_limit;
            plot_en_next  = 1'b0;
            reseed_next   = 1'b0;
            age_next      = init_age;
            ram_re        = job_in_range && (job.data.command == CMD_ADVANCE);
            if (job_in_range && (job.data.command == CMD_INIT))
            begin
                state_next = ST_DRAW_MUL_X;
            end
            else
            begin
                state_next = ST_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lcg_seed_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lcg_seed_reg  <= lcg_seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        in_range_reg <= in_range_next;
        draw_ok_reg  <= draw_ok_next;
        plot_en_reg  <= plot_en_next;
        reseed_reg   <= reseed_next;
        age_reg      <= age_next;
        x_new_reg    <= x_new_next;
        prod_reg     <= prod_next;
        proj_y_reg   <= proj_y_next;
        proj_x_reg   <= proj_x_next;
        out_word_reg <= out_word_next;
    end

`ifndef ASSERT_OFF
    a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == ST_IDLE || state_reg == ST_FINISH))
        else $error("job word taken while a star is in progress");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_READ || state_reg == ST_DRAW_ADD_Y))
        else $error("star memory written outside a write-back step");

    a_seed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DRAW_ADD_X && state_reg != ST_DRAW_ADD_Y) |=> $stable(lcg_seed_reg))
        else $error("LCG seed moved outside a draw");

    a_finish_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !plot.ready) |=> state_reg == ST_FINISH)
        else $error("result dropped while output word stalled");

    a_plot_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.plot_valid) |->
            ($onehot(out_word_reg.pixel_mask) && !out_word_reg.reseeded))
        else $error("plotted word with bad mask or reseed flag");
`endif

endmodule

/* bench/tb.sv */
// Self-checking bench for the starfield particle projector core.
module tb import sfpp_pkg::*;;

    // Table depth of the block under test and the random workload
    localparam int STARS       = 1024;
    localparam int RANDOM_JOBS = 1750;
    localparam int POOL_SIZE   = 16;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int TAIL_CYCLES = 16;

    // Projection scales and screen geometry, kept independent of the package
    localparam int Y_SCALE   = 108 * 65536;
    localparam int X_SCALE   = 144 * 65536;
    localparam int MID_ROW   = 100;
    localparam int MID_COL   = 160;
    localparam int ROWS      = 100;
    localparam int COLS      = 320;
    localparam int ROW_PITCH = 40;

    localparam plot_t NO_PLOT     = '0;
    localparam plot_t RESEED_WORD = '{plot_valid: 1'b0, byte_offset: '0, pixel_mask: '0,
                                      plane_select: PLANE_NONE, reseeded: 1'b1};

    typedef struct {
        job_t  job;
        bit    typed;
        plot_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sfpp_job_if  job_ch ();
    sfpp_plot_if plot_ch ();

    starfield_particle_projector_core #(.STAR_COUNT(STARS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job_ch.sink),
        .plot  (plot_ch.source)
    );

    // Shadow copy of the star table and the LCG, updated as each job word is taken
    logic [AGE_W-1:0]  star_age   [STARS];
    logic [SEED_W-1:0] star_xseed [STARS];
    logic [SEED_W-1:0] star_yseed [STARS];
    bit                star_live  [STARS];
    logic [31:0]       lcg_state;

    plot_t     pending_plots [$];
    stim_row_t stim_rows [$];
    int        star_pool [POOL_SIZE];
    int        mismatches;
    int        cycle_count;
    int        send_idle;
    int        recv_idle;

    // Step the LCG once and hand back a fresh signed 10-bit seed
    function automatic logic [SEED_W-1:0] next_star_seed();
        logic [63:0] prod;
        prod      = 64'h343FD * {32'd0, lcg_state};
        lcg_state = prod[31:0] + 32'h0026_9EC3;
        return prod[41:32] ^ 10'h200;
    endfunction

    // Offset from the screen centre: floor(seed * recip / 2^14)
    function automatic int project_axis(logic [SEED_W-1:0] seed, int scale,
                                        logic [AGE_W-1:0] age);
        int recip;
        int prod;
        recip = (scale / (150 + 4 * int'(age))) >>> 1;
        prod  = int'($signed(seed)) * recip;
        return prod >>> 14;
    endfunction

    // Apply one job to the shadow table and return the plot word it must produce
    function automatic plot_t predict_plot(job_t j);
        plot_t            p;
        int               idx;
        int               row;
        int               col;
        logic [AGE_W-1:0] age;
        p   = NO_PLOT;
        idx = int'(j.star_index);
        if (idx >= STARS)
            return p;
        if (j.command == CMD_INIT)
        begin
            star_age[idx]   = (j.star_index[7:0] == 8'd0) ? 8'd0 : j.star_index[7:0] - 8'd1;
            star_xseed[idx] = next_star_seed();
            star_yseed[idx] = next_star_seed();
            star_live[idx]  = 1'b1;
            return p;
        end
        age           = star_age[idx] - 8'd2;
        star_age[idx] = age;
        if (age > 8'd240)
        begin
            star_xseed[idx] = next_star_seed();
            star_yseed[idx] = next_star_seed();
            p.reseeded      = 1'b1;
            return p;
        end
        if (j.countdown < j.plot_limit)
            return p;
        row = project_axis(star_yseed[idx], Y_SCALE, age) + MID_ROW;
        if (row < 0 || row >= ROWS)
            return p;
        col = project_axis(star_xseed[idx], X_SCALE, age) + MID_COL;
        if (col < 0 || col >= COLS)
            return p;
        p.plot_valid  = 1'b1;
        p.byte_offset = OFS_W'(row * ROW_PITCH + col / 8);
        p.pixel_mask  = 8'h80 >> (col % 8);
        if (age >= 8'd180)
            p.plane_select = PLANE_0;
        else if (age >= 8'd110)
            p.plane_select = PLANE_1;
        else
            p.plane_select = PLANE_BOTH;
        return p;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch at cycle %0d on %s: got %0h, want %0h", cycle_count, field, got, want);
        mismatches++;
    endtask

    task automatic add_row(logic cmd, int idx, int cd, int lim, bit typed, plot_t want);
        stim_row_t r;
        r.job.command    = cmd;
        r.job.star_index = IDX_W'(idx);
        r.job.countdown  = IDX_W'(cd);
        r.job.plot_limit = LIMIT_W'(lim);
        r.typed          = typed;
        r.want           = want;
        stim_rows.push_back(r);
    endtask

    // Offer one job word, idling at random first; queue its plot word once taken.
    // A typed expectation overrides the prediction, but the shadow table still advances.
    task automatic send_job(job_t j, bit typed, plot_t want);
        plot_t predicted;
        while ($urandom_range(0, 99) < send_idle)
        begin
            job_ch.valid <= 1'b0;
            @(posedge clk);
        end
        job_ch.valid <= 1'b1;
        job_ch.data  <= j;
        do
            @(posedge clk);
        while (!job_ch.ready);
        predicted = predict_plot(j);
        pending_plots.push_back(typed ? want : predicted);
    endtask

    // Drop valid and hold off until every plot word owed has arrived, then retune idling
    task automatic drain_and_retune(int s_idle, int r_idle);
        job_ch.valid <= 1'b0;
        while (pending_plots.size() != 0)
            @(posedge clk);
        send_idle = s_idle;
        recv_idle = r_idle;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a run that has not closed by the limit is broken
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: check each plot word taken against the oldest one owed, then pick
    // whether to stall on the next cycle
    initial
    begin
        plot_t got;
        plot_t want;
        plot_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && plot_ch.valid && plot_ch.ready)
            begin
                got = plot_ch.data;
                if (pending_plots.size() == 0)
                begin
                    report_mismatch("word with nothing owed", got, 0);
                end
                else
                begin
                    want = pending_plots.pop_front();
                    if (got.plot_valid !== want.plot_valid)
                        report_mismatch("plot_valid", got.plot_valid, want.plot_valid);
                    if (got.byte_offset !== want.byte_offset)
                        report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
                    if (got.pixel_mask !== want.pixel_mask)
                        report_mismatch("pixel_mask", got.pixel_mask, want.pixel_mask);
                    if (got.plane_select !== want.plane_select)
                        report_mismatch("plane_select", got.plane_select, want.plane_select);
                    if (got.reseeded !== want.reseeded)
                        report_mismatch("reseeded", got.reseeded, want.reseeded);
                end
            end
            plot_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        job_t j;
        int   idx;
        int   n;
        mismatches = 0;
        lcg_state  = 32'd0;
        send_idle  = 25;
        recv_idle  = 69;
        foreach (star_live[i])
            star_live[i] = 1'b0;
        for (n = 0; n < POOL_SIZE; n++)
            star_pool[n] = $urandom_range(0, STARS - 1);

        rst_n        <= 1'b0;
        job_ch.valid <= 1'b0;
        job_ch.data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words. Init ages: index 0, 1, 256 and 512 floor at zero, index 2 gives 1,
        // 243 gives 242, 244 gives 243, 255 and 1023 give 254, 682 gives 169, 341 gives 84.
        add_row(CMD_INIT,    0,    0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    1,    1023, 1024, 1'b1, NO_PLOT);
        add_row(CMD_INIT,    255,  0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    1023, 0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    256,  0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    512,  0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    2,    0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    243,  0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    244,  0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    682,  0,    0,    1'b1, NO_PLOT);
        add_row(CMD_INIT,    341,  0,    0,    1'b1, NO_PLOT);
        // Age zero wraps to 254 and age one to 255: both reseed
        add_row(CMD_ADVANCE, 0,    0,    0,    1'b1, RESEED_WORD);
        add_row(CMD_ADVANCE, 2,    0,    0,    1'b1, RESEED_WORD);
        // 243 drops to 241, just past the wrap threshold; 242 drops to 240 and stays in play
        add_row(CMD_ADVANCE, 244,  0,    0,    1'b1, RESEED_WORD);
        add_row(CMD_ADVANCE, 243,  0,    0,    1'b0, NO_PLOT);
        // Countdown below the limit is skipped, including the widest limit
        add_row(CMD_ADVANCE, 682,  0,    1,    1'b1, NO_PLOT);
        add_row(CMD_ADVANCE, 341,  1023, 1024, 1'b1, NO_PLOT);
        // Stars in all three plane bands; countdown equal to limit is not skipped.
        // Indices 255 and 1023 start at age 254, which wraps, so both reseed here.
        add_row(CMD_ADVANCE, 243,  1023, 0,    1'b0, NO_PLOT);
        add_row(CMD_ADVANCE, 682,  512,  512,  1'b0, NO_PLOT);
        add_row(CMD_ADVANCE, 341,  5,    5,    1'b0, NO_PLOT);
        add_row(CMD_ADVANCE, 255,  700,  2,    1'b0, NO_PLOT);
        add_row(CMD_ADVANCE, 1023, 0,    0,    1'b0, NO_PLOT);
        // Reseed takes precedence over the skip test
        add_row(CMD_ADVANCE, 256,  0,    0,    1'b1, RESEED_WORD);
        add_row(CMD_ADVANCE, 512,  1023, 1024, 1'b1, RESEED_WORD);

        foreach (stim_rows[i])
            send_job(stim_rows[i].job, stim_rows[i].typed, stim_rows[i].want);

        // Random words: mostly advances of a small pool of stars so each one cycles
        // through many ages and reseeds; the rest land anywhere in the table.
        // Never advance a star that has not been initialised.
        for (n = 0; n < RANDOM_JOBS; n++)
        begin
            if (n == RANDOM_JOBS / 3)
                drain_and_retune(69, 25);
            else if (n == 2 * RANDOM_JOBS / 3)
                drain_and_retune(0, 0);
            if ($urandom_range(0, 3) == 0)
                idx = $urandom_range(0, STARS - 1);
            else
                idx = star_pool[$urandom_range(0, POOL_SIZE - 1)];
            j.star_index = IDX_W'(idx);
            if (!star_live[idx] || $urandom_range(0, 99) < 12)
                j.command = CMD_INIT;
            else
                j.command = CMD_ADVANCE;
            j.countdown = IDX_W'($urandom_range(0, 1023));
            case ($urandom_range(0, 3))
                0: j.plot_limit = '0;
                1: j.plot_limit = LIMIT_W'($urandom_range(0, int'(j.countdown)));
                2: j.plot_limit = LIMIT_W'($urandom_range(0, 1024));
                default: j.plot_limit = LIMIT_W'($urandom_range(1000, 1024));
            endcase
            send_job(j, 1'b0, NO_PLOT);
        end
        job_ch.valid <= 1'b0;

        // Let the last words drain, then give the block time to show any stray word
        while (pending_plots.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* filelist.f */
hdl/sfpp_pkg.sv
hdl/sfpp_if.sv
hdl/sfpp_ram.sv
hdl/starfield_particle_projector_core.sv
bench/tb.sv
